### rtl/core/bfs_pkg.sv
// Package for the bitmap find/set/clear engine.
// Command codes, item structs, priority encoder masks and size defaults.
// No dependencies.
`default_nettype none

package bfs_pkg;

    // Default number of 32-bit words in the bitmap
    localparam int BFS_WORDS_DEF = 8;

    // Command codes
    localparam logic [2:0] CMD_WORD_FFS  = 3'd0;
    localparam logic [2:0] CMD_SET       = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_GET       = 3'd3;
    localparam logic [2:0] CMD_FIRST_SET = 3'd4;
    localparam logic [2:0] CMD_NEXT_ZERO = 3'd5;
    localparam logic [2:0] CMD_NEXT_SET  = 3'd6;

    // Binary-search masks of the lowest-set-bit encoder
    localparam logic [31:0] PENC_MASK16 = 32'h0000_ffff;
    localparam logic [31:0] PENC_MASK8  = 32'h00ff_0000;
    localparam logic [31:0] PENC_MASK4  = 32'h0f00_0000;
    localparam logic [31:0] PENC_MASK2  = 32'h3000_0000;
    localparam logic [31:0] PENC_MASK1  = 32'h4000_0000;

    // Command item
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  bit_index;
        logic [8:0]  search_limit;
        logic [31:0] data_word;
    } t_cmd_item;

    // Result item
    typedef struct packed {
        logic [8:0] found_index;
        logic       bit_value;
    } t_result_item;

endpackage

`default_nettype wire

### rtl/core/bfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bfs_penc.sv
// Lowest-set-bit encoder over one 32-bit word, five halving steps.
// A zero word encodes as 31. Depends on bfs_pkg.
`default_nettype none

module bfs_penc
    import bfs_pkg::*;
(
    input  wire logic [31:0] i_word,
    output logic      [4:0]  o_pos
);

    always_comb begin
        logic [31:0] w;
        logic [4:0]  k;
        w = i_word;
        k = 5'd31;
        if (|(w & PENC_MASK16)) begin
            k = k - 5'd16;
            w = w << 16;
        end
        if (|(w & PENC_MASK8)) begin
            k = k - 5'd8;
            w = w << 8;
        end
        if (|(w & PENC_MASK4)) begin
            k = k - 5'd4;
            w = w << 4;
        end
        if (|(w & PENC_MASK2)) begin
            k = k - 5'd2;
            w = w << 2;
        end
        if (|(w & PENC_MASK1)) begin
            k = k - 5'd1;
        end
        o_pos = k;
    end

endmodule

`default_nettype wire

### rtl/core/bitmap_find_set_clear_engine_unit.sv
// Bitmap find/set/clear engine, top level: sequencer, bitmap RAM, shared encoder.
// Depends on bfs_pkg, bfs_ram, bfs_penc.
//
// Usage:
//   An item (i_cmd) is taken at a rising edge with start high and busy low.
//   Every item gives exactly one result on o_result, shown for one cycle with
//   o_valid high. The receiver cannot stall; the result must be taken then.
// Sequence from the accepted item to its result:
//   word_ffs, unused code, out-of-store bit ops, searches whose offset is at
//   or above the limit: no wait state, busy stays low (one item per cycle).
//   set / clear / get: RAM read, then modify/write or report in S_MOD.
//   searches: one S_SCAN step per word, at most min(BITMAP_WORDS, 16)
//   words (8 with the default size). The scan reads one word per cycle from the
//   RAM read port and tests it with the single 32-bit lowest-set-bit encoder.
// Reset:
//   i_rst_n low for one edge empties the bitmap at once (per-word valid
//   flags), drops any item at work and clears o_valid. No clearing pass.
`default_nettype none

module bitmap_find_set_clear_engine_unit
    import bfs_pkg::*;
#(
    parameter int BITMAP_WORDS = BFS_WORDS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire t_cmd_item    i_cmd,
    output logic              busy,
    output logic              o_valid,
    output t_result_item      o_result
);

    localparam int AW         = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WN_W       = (AW > 4) ? AW : 4;
    localparam int BW         = WN_W + 6;
    localparam int STORE_BITS = BITMAP_WORDS * 32;
    localparam logic [8:0] STORE_LIM = (STORE_BITS > 511) ? 9'd511 : 9'(STORE_BITS);
    localparam logic [8:0] FOUND_MAX = (STORE_LIM > 9'd255) ? STORE_LIM : 9'd255;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [8:0]        r_start, n_start;
    logic [8:0]        r_lim, n_lim;
    logic [WN_W-1:0]   r_word, n_word;
    logic [WN_W-1:0]   r_eval_word, n_eval_word;
    logic              r_done, n_done;
    t_result_item      r_out, n_out;
    logic [BITMAP_WORDS-1:0] r_valid;

    logic              acc;
    logic [8:0]        in_start;
    logic [8:0]        in_lim;
    logic [WN_W-1:0]   in_word;
    logic              in_store;

    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;
    logic [31:0]       cur_word;
    logic [31:0]       bit_mask;

    logic [BW-1:0]     base, end_x, lim_x, start_x;
    logic              full_hi;
    logic [4:0]        lo5;
    logic [31:0]       scan_mask;
    logic [31:0]       cand;
    logic              hit;
    logic [31:0]       enc_in;
    logic [4:0]        enc_pos;

    // Input decode
    assign busy     = (r_state != S_IDLE);
    assign acc      = start && !busy;
    assign in_start = (i_cmd.cmd == CMD_FIRST_SET) ? 9'd0 : {1'b0, i_cmd.bit_index};
    assign in_lim   = (i_cmd.search_limit > STORE_LIM) ? STORE_LIM : i_cmd.search_limit;
    assign in_word  = (i_cmd.cmd == CMD_FIRST_SET) ? '0 : WN_W'(i_cmd.bit_index[7:5]);
    assign in_store = ({1'b0, i_cmd.bit_index} < STORE_LIM);

    // Bitmap store
    assign ram_raddr = (r_state == S_SCAN) ? r_word[AW-1:0] : in_word[AW-1:0];
    assign ram_we    = (r_state == S_MOD) && (r_cmd != CMD_GET);
    assign bit_mask  = 32'd1 << r_start[4:0];
    assign cur_word  = r_valid[r_eval_word[AW-1:0]] ? ram_rdata : '0;
    assign ram_wdata = (r_cmd == CMD_SET) ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

    bfs_ram #(
        .WIDTH (32),
        .DEPTH (BITMAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_eval_word[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Per-word written flags; an unwritten word reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_eval_word[AW-1:0]] <= 1'b1;
        end
    end

    // Window of the word under test: [max(start, base), min(lim, base + 32))
    assign base      = {1'b0, r_eval_word, 5'b0};
    assign end_x     = base + BW'(32);
    assign lim_x     = BW'(r_lim);
    assign start_x   = BW'(r_start);
    assign full_hi   = (lim_x >= end_x);
    assign lo5       = (start_x > base) ? r_start[4:0] : 5'd0;
    assign scan_mask = ({32{1'b1}} << lo5)
                     & (full_hi ? {32{1'b1}} : ((32'd1 << r_lim[4:0]) - 32'd1));
    assign cand      = ((r_cmd == CMD_NEXT_ZERO) ? ~cur_word : cur_word) & scan_mask;
    assign hit       = |cand;

    // Shared encoder: supplied word when idle, masked bitmap word while scanning
    assign enc_in = (r_state == S_SCAN) ? cand : i_cmd.data_word;

    bfs_penc u_penc (
        .i_word (enc_in),
        .o_pos  (enc_pos)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_start     = r_start;
        n_lim       = r_lim;
        n_word      = r_word;
        n_eval_word = r_eval_word;
        n_done      = 1'b0;
        n_out       = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd       = i_cmd.cmd;
                    n_start     = in_start;
                    n_lim       = in_lim;
                    n_eval_word = in_word;
                    n_word      = in_word + WN_W'(1);
                    case (i_cmd.cmd)
                        CMD_WORD_FFS: begin
                            n_done            = 1'b1;
                            n_out.found_index = {4'd0, enc_pos};
                        end
                        CMD_SET, CMD_CLEAR, CMD_GET: begin
                            if (in_store) begin
                                n_state = S_MOD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        CMD_FIRST_SET, CMD_NEXT_ZERO, CMD_NEXT_SET: begin
                            if (in_start >= in_lim) begin
                                n_done            = 1'b1;
                                n_out.found_index = in_start;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_cmd == CMD_GET) begin
                    n_out.bit_value = cur_word[r_start[4:0]];
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_done            = 1'b1;
                    n_out.found_index = 9'({r_eval_word, enc_pos});
                    n_state           = S_IDLE;
                end else if (end_x >= lim_x) begin
                    n_done            = 1'b1;
                    n_out.found_index = r_lim;
                    n_state           = S_IDLE;
                end else begin
                    n_eval_word = r_word;
                    n_word      = r_word + WN_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_start     <= n_start;
        r_lim       <= n_lim;
        r_word      <= n_word;
        r_eval_word <= n_eval_word;
        r_out       <= n_out;
    end

    assign o_valid  = r_done;
    assign o_result = r_out;

    // A result only follows an accepted item or work in progress
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result without an item at work");

    // A scanned word always starts below the effective limit
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (base < lim_x))
        else $error("scan past the search limit");

    // The scan moves one word per cycle
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && $past(r_state == S_SCAN))
            |-> (r_eval_word == $past(r_eval_word) + WN_W'(1)))
        else $error("scan skipped or repeated a word");

    // Found index stays within the larger of the store limit and the top offset
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.found_index <= FOUND_MAX))
        else $error("found index out of range");

    // Only a get reports a set bit value
    a_bit_value_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.bit_value) |-> $past(r_cmd == CMD_GET))
        else $error("bit value on a command other than get");

endmodule

`default_nettype wire
